>>> rtl/core/soa_pkg.sv
// soa_pkg: shared constants and types of the slab object allocator.
// No dependencies.
package soa_pkg;

    typedef logic [6:0] t_slot;
    typedef logic [2:0] t_status;

    localparam int unsigned HDR_BYTES = 48;
    localparam int unsigned OBJ_SMALL = 32;
    localparam int unsigned OBJ_LARGE = 128;

    localparam t_slot SLOT_EMPTY = 7'd127;
    localparam t_slot SLOT_MAX   = 7'd127;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CLS_SMALL = 1'b0;
    localparam logic CLS_LARGE = 1'b1;

    localparam t_status STS_OK   = 3'd0;
    localparam t_status STS_ZERO = 3'd1;
    localparam t_status STS_BIG  = 3'd2;
    localparam t_status STS_FULL = 3'd3;
    localparam t_status STS_IGN  = 3'd4;

endpackage

>>> rtl/core/soa_req_if.sv
// soa_req_if: request channel of the slab object allocator.
// Depends on nothing.
interface soa_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [11:0] alloc_size;
    logic [3:0]  obj_page;
    logic [6:0]  free_slot;

    modport source (output valid, operation, alloc_size, obj_page, free_slot, input ready);
    modport sink   (input valid, operation, alloc_size, obj_page, free_slot, output ready);
endinterface

>>> rtl/core/soa_rsp_if.sv
// soa_rsp_if: response channel of the slab object allocator.
// Depends on nothing.
interface soa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  page_index;
    logic [6:0]  slot_index;
    logic [11:0] byte_offset;

    modport source (output valid, status, page_index, slot_index, byte_offset, input ready);
    modport sink   (input valid, status, page_index, slot_index, byte_offset, output ready);
endinterface

>>> rtl/core/slab_object_allocator_unit.sv
// slab_object_allocator_unit: two-class slab allocator sequencer.
// Depends on soa_pkg, soa_req_if, soa_rsp_if and soa_ram.
//
// Usage:
//   i_req carries one request: allocate (alloc_size bytes) or free
//   (obj_page, free_slot). o_rsp returns exactly one response per request
//   with a status and, for a good allocate, page, slot and byte offset.
//   Both channels move a request when valid and ready are high at a clock.
//   One request is worked on at a time; i_req.ready is high while idle.
//   Page records sit in a RAM of NUM_PAGES entries and slot links in a RAM
//   of NUM_PAGES*128 entries, both with registered read data.
//   An allocate walks its class list for a page with a free slot; if none
//   has one, it fills the slot links of the lowest inactive page, or
//   reports full when no page is left. Rejected requests and frees to an
//   inactive page go straight to the response. A free that empties a page
//   unlinks it from its class list, walking the list from its head.
//   A stalled receiver holds the next request only once it has finished.
//   Reset clears only the state, page activity, list heads and output valid.
module slab_object_allocator_unit
    import soa_pkg::*;
#(
    parameter int NUM_PAGES   = 16,
    parameter int PAGE_BYTES  = 4096,
    parameter int SLOTS_SMALL = 126,
    parameter int SLOTS_LARGE = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    soa_req_if.sink   i_req,
    soa_rsp_if.source o_rsp
);

    localparam int PW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LW   = $clog2(NUM_PAGES + 1);
    localparam int AW   = PW + 7;
    localparam int ROOM = (PAGE_BYTES > HDR_BYTES) ? (PAGE_BYTES - HDR_BYTES) : 0;
    localparam int FIT0 = ROOM / OBJ_SMALL;
    localparam int FIT1 = ROOM / OBJ_LARGE;
    localparam int SCA0 = (FIT0 < SLOTS_SMALL) ? FIT0 : SLOTS_SMALL;
    localparam int SCA1 = (FIT1 < SLOTS_LARGE) ? FIT1 : SLOTS_LARGE;
    localparam t_slot SC0 = t_slot'((SCA0 > 127) ? 127 : SCA0);
    localparam t_slot SC1 = t_slot'((SCA1 > 127) ? 127 : SCA1);
    localparam logic [LW-1:0] NULLP = LW'(NUM_PAGES);
    localparam logic [LW-1:0] LASTC = LW'(NUM_PAGES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WALK = 4'd1;
    localparam logic [3:0] S_FIND = 4'd2;
    localparam logic [3:0] S_FILL = 4'd3;
    localparam logic [3:0] S_POPR = 4'd4;
    localparam logic [3:0] S_POPW = 4'd5;
    localparam logic [3:0] S_FCHK = 4'd6;
    localparam logic [3:0] S_UNL  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    typedef struct packed {
        logic          cls;
        t_slot         used;
        t_slot         fh;
        logic [LW-1:0] nxt;
    } t_rec;

    localparam int RW = $bits(t_rec);

    logic [3:0]          r_state, n_state;
    logic                r_cls, n_cls;
    logic [PW-1:0]       r_pg, n_pg;
    logic [LW-1:0]       r_p, n_p;
    logic [LW-1:0]       r_cnt, n_cnt;
    t_slot               r_fill, n_fill;
    t_slot               r_sl, n_sl;
    t_rec                r_rec, n_rec;
    logic [NUM_PAGES-1:0] r_active, n_active;
    logic [LW-1:0]       r_head [2];
    logic [LW-1:0]       n_head [2];

    t_status             r_res_sts, n_res_sts;
    logic [3:0]          r_res_pg, n_res_pg;
    t_slot               r_res_sl, n_res_sl;
    logic [11:0]         r_res_off, n_res_off;

    logic                r_ov;
    t_status             r_o_sts;
    logic [3:0]          r_o_pg;
    t_slot               r_o_sl;
    logic [11:0]         r_o_off;

    logic                w_pg_we;
    logic [PW-1:0]       w_pg_waddr;
    t_rec                w_pg_wdata;
    logic [PW-1:0]       w_pg_raddr;
    logic [RW-1:0]       w_pg_rdata;
    t_rec                w_rec;

    logic                w_lk_we;
    logic [AW-1:0]       w_lk_waddr;
    t_slot               w_lk_wdata;
    logic [AW-1:0]       w_lk_raddr;
    t_slot               w_lk_rdata;

    logic                w_free_found;
    logic [PW-1:0]       w_free_idx;
    logic [PW-1:0]       w_fpg;
    t_slot               w_n;
    t_slot               w_nf;
    logic [LW-1:0]       w_cnt_inc;
    logic [LW-1:0]       w_hp;
    logic [11:0]         w_off;
    logic                w_out_load;

    soa_ram #(.DEPTH(NUM_PAGES), .AW(PW), .DW(RW)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_pg_we),
        .i_waddr (w_pg_waddr),
        .i_wdata (w_pg_wdata),
        .i_raddr (w_pg_raddr),
        .o_rdata (w_pg_rdata)
    );

    soa_ram #(.DEPTH(NUM_PAGES * 128), .AW(AW), .DW(7)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_lk_we),
        .i_waddr (w_lk_waddr),
        .i_wdata (w_lk_wdata),
        .i_raddr (w_lk_raddr),
        .o_rdata (w_lk_rdata)
    );

    assign w_rec     = t_rec'(w_pg_rdata);
    assign w_fpg     = PW'(i_req.obj_page);
    assign w_n       = r_cls ? SC1 : SC0;
    assign w_nf      = w_rec.cls ? SC1 : SC0;
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_hp      = r_head[w_rec.cls];
    assign w_off     = r_rec.cls ? 12'(HDR_BYTES + (32'(r_rec.fh) << 7))
                                 : 12'(HDR_BYTES + (32'(r_rec.fh) << 5));
    assign w_out_load = (r_state == S_OUT) && (!r_ov || o_rsp.ready);

    // lowest inactive page
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int k = NUM_PAGES - 1; k >= 0; k--) begin
            if (!r_active[k]) begin
                w_free_found = 1'b1;
                w_free_idx   = PW'(k);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cls     = r_cls;
        n_pg      = r_pg;
        n_p       = r_p;
        n_cnt     = r_cnt;
        n_fill    = r_fill;
        n_sl      = r_sl;
        n_rec     = r_rec;
        n_active  = r_active;
        n_head    = r_head;
        n_res_sts = r_res_sts;
        n_res_pg  = r_res_pg;
        n_res_sl  = r_res_sl;
        n_res_off = r_res_off;

        w_pg_we    = 1'b0;
        w_pg_waddr = r_pg;
        w_pg_wdata = r_rec;
        w_pg_raddr = r_p[PW-1:0];
        w_lk_we    = 1'b0;
        w_lk_waddr = {r_pg, r_sl};
        w_lk_wdata = r_fill;
        w_lk_raddr = {r_pg, r_rec.fh};

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res_sts = STS_OK;
                    n_res_pg  = '0;
                    n_res_sl  = '0;
                    n_res_off = '0;
                    n_cnt     = '0;
                    if (i_req.operation == OP_ALLOC) begin
                        if (i_req.alloc_size == 12'd0) begin
                            n_res_sts = STS_ZERO;
                            n_state   = S_OUT;
                        end else if (i_req.alloc_size > 12'd128) begin
                            n_res_sts = STS_BIG;
                            n_state   = S_OUT;
                        end else begin
                            n_cls = (i_req.alloc_size > 12'd32) ? CLS_LARGE : CLS_SMALL;
                            n_p   = r_head[n_cls];
                            w_pg_raddr = n_p[PW-1:0];
                            n_state = (n_p >= NULLP) ? S_FIND : S_WALK;
                        end
                    end else begin
                        if ((32'(i_req.obj_page) >= NUM_PAGES) || !r_active[w_fpg]) begin
                            n_res_sts = STS_IGN;
                            n_state   = S_OUT;
                        end else begin
                            n_pg       = w_fpg;
                            n_sl       = i_req.free_slot;
                            w_pg_raddr = w_fpg;
                            n_state    = S_FCHK;
                        end
                    end
                end
            end
            S_WALK: begin
                if (w_rec.fh != SLOT_EMPTY) begin
                    n_rec   = w_rec;
                    n_pg    = r_p[PW-1:0];
                    n_state = S_POPR;
                end else begin
                    n_p   = w_rec.nxt;
                    n_cnt = w_cnt_inc;
                    w_pg_raddr = w_rec.nxt[PW-1:0];
                    if ((w_cnt_inc == LASTC) || (w_rec.nxt >= NULLP)) begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (!w_free_found || (w_n == '0)) begin
                    n_res_sts = STS_FULL;
                    n_state   = S_OUT;
                end else begin
                    n_pg    = w_free_idx;
                    n_fill  = '0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                w_lk_we    = 1'b1;
                w_lk_waddr = {r_pg, r_fill};
                w_lk_wdata = (r_fill == '0) ? SLOT_EMPTY : (r_fill - 1'b1);
                n_fill     = r_fill + 1'b1;
                if (r_fill == (w_n - 1'b1)) begin
                    n_rec.cls      = r_cls;
                    n_rec.used     = '0;
                    n_rec.fh       = w_n - 1'b1;
                    n_rec.nxt      = r_head[r_cls];
                    n_head[r_cls]  = LW'(r_pg);
                    n_active[r_pg] = 1'b1;
                    n_state        = S_POPR;
                end
            end
            S_POPR: begin
                n_state = S_POPW;
            end
            S_POPW: begin
                w_pg_we         = 1'b1;
                w_pg_wdata.cls  = r_rec.cls;
                w_pg_wdata.used = r_rec.used + 1'b1;
                w_pg_wdata.fh   = w_lk_rdata;
                w_pg_wdata.nxt  = r_rec.nxt;
                n_res_sts = STS_OK;
                n_res_pg  = 4'(r_pg);
                n_res_sl  = r_rec.fh;
                n_res_off = w_off;
                n_state   = S_OUT;
            end
            S_FCHK: begin
                n_state = S_OUT;
                if (r_sl >= w_nf) begin
                    n_res_sts = STS_IGN;
                end else begin
                    w_lk_we    = 1'b1;
                    w_lk_waddr = {r_pg, r_sl};
                    w_lk_wdata = w_rec.fh;
                    n_rec      = w_rec;
                    n_rec.fh   = r_sl;
                    w_pg_wdata = n_rec;
                    if (w_rec.used == '0) begin
                        w_pg_we = 1'b1;
                    end else if (w_rec.used != 7'd1) begin
                        w_pg_we         = 1'b1;
                        w_pg_wdata.used = w_rec.used - 1'b1;
                    end else if (w_hp == LW'(r_pg)) begin
                        n_head[w_rec.cls] = w_rec.nxt;
                        n_active[r_pg]    = 1'b0;
                    end else if (w_hp >= NULLP) begin
                        n_active[r_pg] = 1'b0;
                    end else begin
                        n_p        = w_hp;
                        w_pg_raddr = w_hp[PW-1:0];
                        n_state    = S_UNL;
                    end
                end
            end
            S_UNL: begin
                if (w_rec.nxt == LW'(r_pg)) begin
                    w_pg_we        = 1'b1;
                    w_pg_waddr     = r_p[PW-1:0];
                    w_pg_wdata     = w_rec;
                    w_pg_wdata.nxt = r_rec.nxt;
                    n_active[r_pg] = 1'b0;
                    n_state        = S_OUT;
                end else begin
                    n_p        = w_rec.nxt;
                    n_cnt      = w_cnt_inc;
                    w_pg_raddr = w_rec.nxt[PW-1:0];
                    if ((w_cnt_inc == LASTC) || (w_rec.nxt >= NULLP)) begin
                        n_active[r_pg] = 1'b0;
                        n_state        = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_head[0] <= NULLP;
            r_head[1] <= NULLP;
            r_ov      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_head   <= n_head;
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls     <= n_cls;
        r_pg      <= n_pg;
        r_p       <= n_p;
        r_cnt     <= n_cnt;
        r_fill    <= n_fill;
        r_sl      <= n_sl;
        r_rec     <= n_rec;
        r_res_sts <= n_res_sts;
        r_res_pg  <= n_res_pg;
        r_res_sl  <= n_res_sl;
        r_res_off <= n_res_off;
        if (w_out_load) begin
            r_o_sts <= r_res_sts;
            r_o_pg  <= r_res_pg;
            r_o_sl  <= r_res_sl;
            r_o_off <= r_res_off;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_sts;
    assign o_rsp.page_index  = r_o_pg;
    assign o_rsp.slot_index  = r_o_sl;
    assign o_rsp.byte_offset = r_o_off;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while previous one in flight");

    a_head0_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head[0] < NULLP) |-> r_active[r_head[0][PW-1:0]])
        else $error("small class list head is not an active page");

    a_head1_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head[1] < NULLP) |-> r_active[r_head[1][PW-1:0]])
        else $error("large class list head is not an active page");

    a_pop_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POPW) |-> r_active[r_pg])
        else $error("pop from inactive page");
`endif

endmodule

>>> rtl/core/soa_ram.sv
// soa_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module soa_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
